### rtl/sobel_pkg.sv
// Shared types, constants and helper functions of the Sobel edge magnitude block.
package sobel_pkg;

  localparam int unsigned MaxWidthDefault = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned RowW = 13;
  localparam int unsigned CfgWidthW = 11;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned PixW = 24;
  localparam int unsigned AccW = 12;
  localparam int unsigned AbsW = 11;
  localparam int unsigned SumW = 24;
  localparam int unsigned NumTaps = 9;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OpPixel = 1'b0,
    OpDrain = 1'b1
  } op_e;

  typedef enum logic [5:0] {
    BackIdle   = 6'b000001,
    BackWrite  = 6'b000010,
    BackRead   = 6'b000100,
    BackSquare = 6'b001000,
    BackRoot   = 6'b010000,
    BackPush   = 6'b100000
  } back_state_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_last;
  } out_item_t;

  // Next row slot of the three-row ring.
  function automatic logic [1:0] slot_inc(logic [1:0] slot);
    logic [1:0] res;
    res = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
    return res;
  endfunction

  // Ring slot holding the row at offset (ofs - 1) from the row in base.
  function automatic logic [1:0] slot_of(logic [1:0] base, logic [1:0] ofs);
    logic [2:0] sum;
    sum = 3'(base) + 3'(ofs) + 3'd2;
    if (sum >= 3'd3) begin
      sum = sum - 3'd3;
    end
    if (sum >= 3'd3) begin
      sum = sum - 3'd3;
    end
    return sum[1:0];
  endfunction

  // Horizontal kernel weight of the tap at row index ti and column index tj.
  function automatic logic signed [2:0] weight_x(logic [1:0] ti, logic [1:0] tj);
    logic signed [2:0] w;
    w = 3'sd0;
    if (tj == 2'd0) begin
      w = (ti == 2'd1) ? -3'sd2 : -3'sd1;
    end else if (tj == 2'd2) begin
      w = (ti == 2'd1) ? 3'sd2 : 3'sd1;
    end
    return w;
  endfunction

  function automatic logic signed [2:0] weight_y(logic [1:0] ti, logic [1:0] tj);
    return weight_x(tj, ti);
  endfunction

endpackage

### rtl/sobel_fifo.sv
// Small first-in first-out queue of generic beats.
module sobel_fifo #(
  parameter type T = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              store_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/sobel_front.sv
// Front end: raster position tracking; jobs for pixels and released results.
module sobel_front #(
  parameter int unsigned MaxWidth = sobel_pkg::MaxWidthDefault,
  parameter type job_t = logic
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  sobel_pkg::in_item_t            item_i,
  input  logic [sobel_pkg::CfgWidthW-1:0]  frame_width_i,
  input  logic [sobel_pkg::CfgHeightW-1:0] frame_height_i,
  output logic                           job_push_o,
  output job_t                           job_o
);

  localparam int unsigned ColW = $clog2(MaxWidth) + 1;
  localparam int unsigned RowW = sobel_pkg::RowW;
  localparam int unsigned AddrW = $clog2(3 * MaxWidth);

  logic [ColW-1:0] eff_w;
  logic [RowW-1:0] eff_h;
  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d, ncol, nx;
  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d, nrow, ny;
  logic [1:0]      in_slot_q, in_slot_d, out_slot_q, out_slot_d, nslot;
  logic            ahead_q, ahead_d, nahead, is_pixel, ready, out_wrap;
  logic [1:0]      byp_ti, byp_tj;
  logic            byp_row_ok, byp_col_ok;

  always_comb begin
    if (frame_width_i == '0) begin
      eff_w = ColW'(1);
    end else if (32'(frame_width_i) > MaxWidth) begin
      eff_w = ColW'(MaxWidth);
    end else begin
      eff_w = ColW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      eff_h = RowW'(1);
    end else if (32'(frame_height_i) > sobel_pkg::MaxHeight) begin
      eff_h = RowW'(sobel_pkg::MaxHeight);
    end else begin
      eff_h = RowW'(frame_height_i);
    end
  end

  assign is_pixel = (item_i.operation == sobel_pkg::OpPixel);

  always_comb begin
    ncol   = in_col_q;
    nrow   = in_row_q;
    nslot  = in_slot_q;
    nahead = ahead_q;
    if (is_pixel) begin
      if ({1'b0, in_col_q} + 1'b1 >= {1'b0, eff_w}) begin
        ncol  = '0;
        nslot = sobel_pkg::slot_inc(in_slot_q);
        if ({1'b0, in_row_q} + 1'b1 >= {1'b0, eff_h}) begin
          nrow   = '0;
          nahead = 1'b1;
        end else begin
          nrow = in_row_q + 1'b1;
        end
      end else begin
        ncol = in_col_q + 1'b1;
      end
    end
    ny = ({1'b0, out_row_q} + 1'b1 < {1'b0, eff_h}) ? out_row_q + 1'b1 : eff_h - 1'b1;
    nx = ({1'b0, out_col_q} + 1'b1 < {1'b0, eff_w}) ? out_col_q + 1'b1 : eff_w - 1'b1;
    ready = nahead || (nrow > ny) || ((nrow == ny) && (ncol > nx));
  end

  // The incoming pixel itself may be one of the taps of the result it releases.
  always_comb begin
    byp_ti     = 2'd1;
    byp_row_ok = 1'b1;
    if (in_row_q == out_row_q) begin
      byp_ti = 2'd1;
    end else if ({1'b0, in_row_q} == {1'b0, out_row_q} + 1'b1) begin
      byp_ti = 2'd2;
    end else if ({1'b0, in_row_q} + 1'b1 == {1'b0, out_row_q}) begin
      byp_ti = 2'd0;
    end else begin
      byp_row_ok = 1'b0;
    end
    byp_tj     = 2'd1;
    byp_col_ok = 1'b1;
    if (in_col_q == out_col_q) begin
      byp_tj = 2'd1;
    end else if ({1'b0, in_col_q} == {1'b0, out_col_q} + 1'b1) begin
      byp_tj = 2'd2;
    end else if ({1'b0, in_col_q} + 1'b1 == {1'b0, out_col_q}) begin
      byp_tj = 2'd0;
    end else begin
      byp_col_ok = 1'b0;
    end
  end

  always_comb begin
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    out_wrap   = 1'b0;
    if (ready) begin
      if ({1'b0, out_col_q} + 1'b1 >= {1'b0, eff_w}) begin
        out_col_d  = '0;
        out_slot_d = sobel_pkg::slot_inc(out_slot_q);
        if ({1'b0, out_row_q} + 1'b1 >= {1'b0, eff_h}) begin
          out_row_d = '0;
          out_wrap  = 1'b1;
        end else begin
          out_row_d = out_row_q + 1'b1;
        end
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_slot_d = in_slot_q;
    ahead_d   = ahead_q;
    if (is_pixel) begin
      in_col_d  = ncol;
      in_row_d  = nrow;
      in_slot_d = nslot;
      ahead_d   = nahead;
    end
    if (out_wrap) begin
      ahead_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      ahead_q    <= 1'b0;
    end else if (accept_i) begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      ahead_q    <= ahead_d;
    end
  end

  always_comb begin
    job_o.wr     = is_pixel;
    job_o.addr   = AddrW'(32'(in_slot_q) * MaxWidth + 32'(in_col_q));
    job_o.pix    = {item_i.red_in, item_i.green_in, item_i.blue_in};
    job_o.calc   = ready;
    job_o.orow   = out_row_q;
    job_o.ocol   = out_col_q;
    job_o.oslot  = out_slot_q;
    job_o.last   = (out_row_q == eff_h - 1'b1) && (out_col_q == eff_w - 1'b1);
    job_o.h      = eff_h;
    job_o.w      = eff_w;
    job_o.byp    = is_pixel && !ahead_q && byp_row_ok && byp_col_ok;
    job_o.byp_ti = byp_ti;
    job_o.byp_tj = byp_tj;
  end

  assign job_push_o = accept_i && (is_pixel || ready);

endmodule

### rtl/sobel_back.sv
// Back end: line store, nine-tap gradient accumulation and bit-serial magnitude.
module sobel_back #(
  parameter int unsigned MaxWidth = sobel_pkg::MaxWidthDefault,
  parameter type job_t = logic
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  job_t                 job_i,
  output logic                 job_pop_o,
  output logic                 res_push_o,
  output sobel_pkg::out_item_t res_o,
  input  logic                 res_full_i
);

  localparam int unsigned ColW = $clog2(MaxWidth) + 1;
  localparam int unsigned AddrW = $clog2(3 * MaxWidth);
  localparam int unsigned Depth = 3 * MaxWidth;
  localparam int unsigned AccW = sobel_pkg::AccW;
  localparam int unsigned AbsW = sobel_pkg::AbsW;
  localparam int unsigned SumW = sobel_pkg::SumW;

  sobel_pkg::back_state_e state_q, state_d;
  job_t                   job_q;

  logic [sobel_pkg::PixW-1:0] mem [Depth];
  logic [sobel_pkg::PixW-1:0] rdata_q;

  logic [3:0] cnt_q;
  logic [1:0] ti_q, tj_q, tap_ti_q, tap_tj_q;
  logic       rd_vld_q, tap_ok_q, tap_ok, tap_byp_q;
  logic [2:0] step_q;
  logic [1:0] rd_slot;
  logic [ColW-1:0] rd_col;
  logic [AddrW-1:0] rd_addr;
  logic       mem_we, mem_re;

  logic signed [AccW-1:0] gx_q [3];
  logic signed [AccW-1:0] gy_q [3];
  logic [SumW-1:0]        s4_q [3];
  logic [7:0]             r_q  [3];

  assign mem_we = (state_q == sobel_pkg::BackWrite) && job_q.wr;
  assign mem_re = (state_q == sobel_pkg::BackRead) && (cnt_q < 4'(sobel_pkg::NumTaps))
                  && tap_ok;

  always_comb begin
    tap_ok = 1'b1;
    if ((ti_q == 2'd0) && (job_q.orow == '0)) begin
      tap_ok = 1'b0;
    end
    if ((ti_q == 2'd2) && ({1'b0, job_q.orow} + 1'b1 >= {1'b0, job_q.h})) begin
      tap_ok = 1'b0;
    end
    if ((tj_q == 2'd0) && (job_q.ocol == '0)) begin
      tap_ok = 1'b0;
    end
    if ((tj_q == 2'd2) && ({1'b0, job_q.ocol} + 1'b1 >= {1'b0, job_q.w})) begin
      tap_ok = 1'b0;
    end
    rd_slot = sobel_pkg::slot_of(job_q.oslot, ti_q);
    rd_col  = ColW'({1'b0, job_q.ocol} + (ColW + 1)'(tj_q) - 1'b1);
    rd_addr = AddrW'(32'(rd_slot) * MaxWidth + 32'(rd_col));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[job_q.addr] <= job_q.pix;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // The taps are read before the pixel of the same job is written.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sobel_pkg::BackIdle: begin
        if (job_valid_i) begin
          state_d = job_i.calc ? sobel_pkg::BackRead : sobel_pkg::BackWrite;
        end
      end
      sobel_pkg::BackRead: begin
        if (cnt_q == 4'(sobel_pkg::NumTaps)) begin
          state_d = sobel_pkg::BackSquare;
        end
      end
      sobel_pkg::BackSquare: begin
        state_d = sobel_pkg::BackRoot;
      end
      sobel_pkg::BackRoot: begin
        if (step_q == '0) begin
          state_d = sobel_pkg::BackWrite;
        end
      end
      sobel_pkg::BackWrite: begin
        state_d = job_q.calc ? sobel_pkg::BackPush : sobel_pkg::BackIdle;
      end
      sobel_pkg::BackPush: begin
        if (!res_full_i) begin
          state_d = sobel_pkg::BackIdle;
        end
      end
      default: begin
        state_d = sobel_pkg::BackIdle;
      end
    endcase
  end

  assign job_pop_o = (state_q == sobel_pkg::BackIdle) && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sobel_pkg::BackIdle;
      cnt_q    <= '0;
      ti_q     <= '0;
      tj_q     <= '0;
      rd_vld_q <= 1'b0;
      step_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        sobel_pkg::BackIdle: begin
          cnt_q    <= '0;
          ti_q     <= '0;
          tj_q     <= '0;
          rd_vld_q <= 1'b0;
        end
        sobel_pkg::BackRead: begin
          if (cnt_q < 4'(sobel_pkg::NumTaps)) begin
            cnt_q    <= cnt_q + 1'b1;
            rd_vld_q <= 1'b1;
            if (tj_q == 2'd2) begin
              tj_q <= '0;
              ti_q <= ti_q + 1'b1;
            end else begin
              tj_q <= tj_q + 1'b1;
            end
          end else begin
            rd_vld_q <= 1'b0;
          end
        end
        sobel_pkg::BackSquare: begin
          step_q <= 3'd7;
        end
        sobel_pkg::BackRoot: begin
          step_q <= step_q - 1'b1;
        end
        default: begin
          rd_vld_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (state_q == sobel_pkg::BackRead) begin
      tap_ok_q  <= tap_ok;
      tap_ti_q  <= ti_q;
      tap_tj_q  <= tj_q;
      tap_byp_q <= job_q.byp && (ti_q == job_q.byp_ti) && (tj_q == job_q.byp_tj);
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic [7:0]             v;
    logic signed [2:0]      wx, wy;
    logic signed [AccW-1:0] px, py;
    logic [AbsW-1:0]        ax, ay;
    logic [7:0]             cand;
    logic [8:0]             odd;
    logic [17:0]            odd_sq;

    always_comb begin
      v  = tap_byp_q ? job_q.pix[8*ch +: 8] : rdata_q[8*ch +: 8];
      wx = sobel_pkg::weight_x(tap_ti_q, tap_tj_q);
      wy = sobel_pkg::weight_y(tap_ti_q, tap_tj_q);
      px = $signed({{(AccW-8){1'b0}}, v}) * $signed({{(AccW-3){wx[2]}}, wx});
      py = $signed({{(AccW-8){1'b0}}, v}) * $signed({{(AccW-3){wy[2]}}, wy});
      ax = gx_q[ch][AccW-1] ? AbsW'(-gx_q[ch]) : AbsW'(gx_q[ch]);
      ay = gy_q[ch][AccW-1] ? AbsW'(-gy_q[ch]) : AbsW'(gy_q[ch]);
      cand   = r_q[ch] | (8'd1 << step_q);
      odd    = {cand, 1'b0} - 9'd1;
      odd_sq = odd * odd;
    end

    always_ff @(posedge clk_i) begin
      case (state_q)
        sobel_pkg::BackIdle: begin
          gx_q[ch] <= '0;
          gy_q[ch] <= '0;
        end
        sobel_pkg::BackRead: begin
          if (rd_vld_q && tap_ok_q) begin
            gx_q[ch] <= gx_q[ch] + px;
            gy_q[ch] <= gy_q[ch] + py;
          end
        end
        sobel_pkg::BackSquare: begin
          s4_q[ch] <= SumW'({2'b00, 22'(ax * ax)} + {2'b00, 22'(ay * ay)}) << 2;
          r_q[ch]  <= '0;
        end
        sobel_pkg::BackRoot: begin
          if (SumW'(odd_sq) <= s4_q[ch]) begin
            r_q[ch] <= cand;
          end
        end
        default: begin
          r_q[ch] <= r_q[ch];
        end
      endcase
    end
  end

  assign res_push_o       = (state_q == sobel_pkg::BackPush) && !res_full_i;
  assign res_o.blue_out   = r_q[0];
  assign res_o.green_out  = r_q[1];
  assign res_o.red_out    = r_q[2];
  assign res_o.frame_last = job_q.last;

  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sobel_pkg::BackRead) |-> (cnt_q <= 4'(sobel_pkg::NumTaps)))
    else $error("Tap counter ran past the last tap.");

  a_push_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (state_q == sobel_pkg::BackIdle))
    else $error("Back end did not return to idle after a result beat.");

  a_data_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == sobel_pkg::BackRead))
    else $error("Tap data marked valid without a preceding read.");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> ((state_q == sobel_pkg::BackRead) || (state_q == sobel_pkg::BackWrite)))
    else $error("Popped job was not started.");

endmodule

### rtl/sobel_edge_magnitude.sv
// Top level of the streaming Sobel edge magnitude block.
// Pixels enter in raster order through a queue-like port; each pixel beat is written to a
// three-row line store, and when a beat completes an output neighborhood the back end first
// reads the nine taps one per cycle from the single-port line store, squares the gradients and
// resolves the rounded magnitude one bit per cycle, then writes the pixel. A beat that yields a
// result occupies the back end through its read, square, root, write and push states, a pixel
// beat without a result only through its write state, and a drain beat with nothing pending
// not at all; a two-entry job queue lets the input side run ahead while the back end works, and
// a two-entry result queue holds finished beats until they are popped. The line store needs no
// clearing pass after reset. Width and height may only be changed while the block is idle.
module sobel_edge_magnitude #(
  parameter int unsigned MaxWidth = sobel_pkg::MaxWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  sobel_pkg::in_item_t            in_item_i,
  output logic                           empty,
  input  logic                           pop,
  output sobel_pkg::out_item_t           out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  sobel_pkg::cfg_reg_e            cfg_index_i,
  input  logic [sobel_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ColW = $clog2(MaxWidth) + 1;
  localparam int unsigned AddrW = $clog2(3 * MaxWidth);

  typedef struct packed {
    logic                          wr;
    logic [AddrW-1:0]              addr;
    logic [sobel_pkg::PixW-1:0]    pix;
    logic                          calc;
    logic [sobel_pkg::RowW-1:0]    orow;
    logic [ColW-1:0]               ocol;
    logic [1:0]                    oslot;
    logic                          last;
    logic [sobel_pkg::RowW-1:0]    h;
    logic [ColW-1:0]               w;
    logic                          byp;
    logic [1:0]                    byp_ti;
    logic [1:0]                    byp_tj;
  } job_t;

  logic [sobel_pkg::CfgWidthW-1:0]  frame_width_q;
  logic [sobel_pkg::CfgHeightW-1:0] frame_height_q;
  logic                             accept, job_push, job_full, job_empty, job_pop;
  logic                             res_push, res_full;
  job_t                             job_in, job_out;
  sobel_pkg::out_item_t             res;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign full        = job_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= sobel_pkg::CfgWidthW'(640);
      frame_height_q <= sobel_pkg::CfgHeightW'(480);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sobel_pkg::CfgFrameWidth: begin
          frame_width_q <= cfg_data_i[sobel_pkg::CfgWidthW-1:0];
        end
        sobel_pkg::CfgFrameHeight: begin
          frame_height_q <= cfg_data_i[sobel_pkg::CfgHeightW-1:0];
        end
        default: begin
          frame_width_q <= frame_width_q;
        end
      endcase
    end
  end

  sobel_front #(
    .MaxWidth(MaxWidth),
    .job_t   (job_t)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (in_item_i),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  sobel_fifo #(
    .T    (job_t),
    .Depth(sobel_pkg::QueueDepth)
  ) u_job_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o (job_out),
    .empty_o(job_empty)
  );

  sobel_back #(
    .MaxWidth(MaxWidth),
    .job_t   (job_t)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .res_push_o (res_push),
    .res_o      (res),
    .res_full_i (res_full)
  );

  sobel_fifo #(
    .T    (sobel_pkg::out_item_t),
    .Depth(sobel_pkg::QueueDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

endmodule
